[src/soc_pkg.sv]
// Shared types and constants of the segment overlap cost block.
// Used by the channel interfaces and the top level, which sizes the reference RAM.
`default_nettype none
package soc_pkg;

  localparam int unsigned MaxRefs  = 1024;
  localparam int unsigned RefIdxW  = $clog2(MaxRefs);
  localparam int unsigned RefCntW  = RefIdxW + 1;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned LabelW   = 16;
  localparam int unsigned CostW    = 16;
  localparam int unsigned BestW    = 10;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  // signed width that holds any difference of two times minus an overlap
  localparam int unsigned CalcW    = TimeW + 2;

  typedef enum logic [ReqW-1:0] {
    ReqClear  = 2'd0,
    ReqAppend = 2'd1,
    ReqQuery  = 2'd2
  } req_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEps = 2'd0,
    CfgBos = 2'd1,
    CfgEos = 2'd2,
    CfgSil = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StSsStart,
    StSsEval,
    StEsStart,
    StEsEval,
    StWinStart,
    StScan,
    StCost,
    StResp
  } state_e;

  typedef struct packed {
    logic [ReqW-1:0]   req_type;
    logic [TimeW-1:0]  seg_start;
    logic [TimeW-1:0]  seg_end;
    logic [LabelW-1:0] seg_label;
  } req_t;

  typedef struct packed {
    logic [CostW-1:0]   cost;
    logic [BestW-1:0]   best_index;
    logic [StatusW-1:0] status;
  } rsp_t;

  // one stored reference entry
  typedef struct packed {
    logic [TimeW-1:0]  r_start;
    logic [TimeW-1:0]  r_stop;
    logic [LabelW-1:0] r_label;
  } ref_entry_t;

  localparam int unsigned EntryW = $bits(ref_entry_t);

endpackage
`default_nettype wire

[src/soc_if.sv]
// Valid/ready channel interfaces for request and response words.
// Depends on soc_pkg for the payload structs.
`default_nettype none
interface soc_req_if;
  logic            valid;
  logic            ready;
  soc_pkg::req_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface soc_rsp_if;
  logic            valid;
  logic            ready;
  soc_pkg::rsp_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/soc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module soc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[src/segment_overlap_cost.sv]
// Segment overlap cost block: one request channel in, one response channel out.
// Request words carry req_type, seg_start, seg_end and seg_label. A clear empties
// the reference list and gives no response. An append stores one reference
// segment in the next free entry and answers with status ok, or with status full
// when all entries are in use (the segment is then dropped). A query answers with
// cost, best_index and status.
// One word is worked on at a time; the request side is ready only in idle.
// Appends, epsilon queries and empty-list queries go straight from idle to the
// response state; a query's time is set by the single read port of the
// reference RAM, which serves both binary searches and the window scan at one
// entry per cycle.
// Responses sit in an output register: a stalled receiver holds the response
// there while the block already takes and works on the next request; the block
// only waits when a second response is ready before the first has been taken.
// Reset empties the list and restores the label registers (eps 0, bos 1, eos 2,
// sil 3); the RAM contents are not cleared and need no clearing pass.
// Depends on soc_pkg, soc_if and soc_ram.
`default_nettype none
module segment_overlap_cost (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [soc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [soc_pkg::CfgDataW-1:0]    cfg_data_i,
  soc_req_if.sink                              req_i,
  soc_rsp_if.source                            rsp_o
);

  localparam int unsigned IdxW = soc_pkg::RefIdxW;
  localparam int unsigned CntW = soc_pkg::RefCntW;
  localparam int unsigned TW   = soc_pkg::TimeW;
  localparam int unsigned LW   = soc_pkg::LabelW;
  localparam int unsigned CW   = soc_pkg::CalcW;

  // label registers
  logic [LW-1:0] eps_q, bos_q, eos_q, sil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= LW'(0);
      bos_q <= LW'(1);
      eos_q <= LW'(2);
      sil_q <= LW'(3);
    end else if (cfg_we_i) begin
      case (soc_pkg::cfg_idx_e'(cfg_idx_i))
        soc_pkg::CfgEps: eps_q <= cfg_data_i;
        soc_pkg::CfgBos: bos_q <= cfg_data_i;
        soc_pkg::CfgEos: eos_q <= cfg_data_i;
        soc_pkg::CfgSil: sil_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  soc_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] l_q, l_d, r_q, r_d, m_q, m_d;
  logic [IdxW-1:0] lo_q, lo_d, hi_q, hi_d, idx_q, idx_d;
  logic            rsp_vld_q, rsp_vld_d;

  // payload state
  logic [TW-1:0]          q_start_q, q_start_d, q_end_q, q_end_d;
  logic [LW-1:0]          q_label_q, q_label_d;
  soc_pkg::ref_entry_t    best_q, best_d;
  logic [TW-1:0]          best_ov_q, best_ov_d;
  logic [IdxW-1:0]        best_idx_q, best_idx_d;
  soc_pkg::rsp_t          res_q, res_d, rsp_q, rsp_d;

  // RAM port
  logic                   ram_we;
  logic [IdxW-1:0]        ram_waddr, ram_raddr;
  soc_pkg::ref_entry_t    ram_wdata, rd;

  soc_ram #(
    .Width (soc_pkg::EntryW),
    .Depth (soc_pkg::MaxRefs)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  // binary search step on the word just read at m_q
  logic [TW-1:0]   key, tgt;
  logic            hit, step_up, srch_done;
  logic [IdxW-1:0] nl, nr, nm, last_idx;
  logic [CntW-1:0] init_sum, step_sum;
  logic            init_adj;

  assign last_idx  = IdxW'(cnt_q - CntW'(1));
  assign key       = (state_q == soc_pkg::StSsEval) ? rd.r_start : rd.r_stop;
  assign tgt       = (state_q == soc_pkg::StSsEval) ? q_start_q : q_end_q;
  assign hit       = (tgt == key);
  assign step_up   = hit || (tgt > key);
  assign nl        = step_up ? m_q : l_q;
  assign nr        = step_up ? r_q : m_q;
  assign srch_done = hit || (({1'b0, nl} + CntW'(1)) == {1'b0, nr});
  assign step_sum  = {1'b0, nl} + {1'b0, nr};
  assign nm        = IdxW'(step_sum >> 1);
  assign init_sum  = {1'b0, l_q} + {1'b0, r_q};
  assign init_adj  = (({1'b0, l_q} + CntW'(1)) == {1'b0, r_q});

  // overlap of the query with the word just read in the window scan
  logic [TW-1:0] ov_min, ov_max, ov;
  logic          take;

  assign ov_min = (rd.r_stop < q_end_q) ? rd.r_stop : q_end_q;
  assign ov_max = (rd.r_start > q_start_q) ? rd.r_start : q_start_q;
  assign ov     = (ov_min > ov_max) ? (ov_min - ov_max) : TW'(0);
  assign take   = (idx_q == lo_q) || (ov > best_ov_q);

  // cost of the chosen reference
  logic [TW-1:0]        uni_hi, uni_lo;
  logic signed [CW-1:0] uni, qlen, ovs, c;
  logic                 lbl_eq, lbl_special;
  logic [soc_pkg::CostW-1:0] cost_sat;

  assign uni_hi      = (best_q.r_stop > q_end_q) ? best_q.r_stop : q_end_q;
  assign uni_lo      = (best_q.r_start < q_start_q) ? best_q.r_start : q_start_q;
  assign uni         = $signed({2'b00, uni_hi}) - $signed({2'b00, uni_lo});
  assign qlen        = $signed({2'b00, q_end_q}) - $signed({2'b00, q_start_q});
  assign ovs         = $signed({2'b00, best_ov_q});
  assign lbl_eq      = (q_label_q == best_q.r_label);
  assign lbl_special = (q_label_q == bos_q) || (q_label_q == eos_q) ||
                       (q_label_q == sil_q);

  always_comb begin
    if (!lbl_eq) begin
      c = uni;
    end else if (lbl_special) begin
      c = qlen - ovs;
    end else begin
      c = uni - ovs;
    end
    if (c < 0) begin
      cost_sat = '0;
    end else if (c > $signed({2'b00, {soc_pkg::CostW{1'b1}}})) begin
      cost_sat = '1;
    end else begin
      cost_sat = soc_pkg::CostW'(c);
    end
  end

  assign req_i.ready = (state_q == soc_pkg::StIdle);
  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    l_d        = l_q;
    r_d        = r_q;
    m_d        = m_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    idx_d      = idx_q;
    q_start_d  = q_start_q;
    q_end_d    = q_end_q;
    q_label_d  = q_label_q;
    best_d     = best_q;
    best_ov_d  = best_ov_q;
    best_idx_d = best_idx_q;
    res_d      = res_q;
    rsp_d      = rsp_q;
    rsp_vld_d  = rsp_vld_q && !rsp_o.ready;
    ram_we     = 1'b0;
    ram_waddr  = cnt_q[IdxW-1:0];
    ram_wdata  = '{r_start: req_i.data.seg_start, r_stop: req_i.data.seg_end,
                   r_label: req_i.data.seg_label};
    ram_raddr  = m_q;

    case (state_q)
      soc_pkg::StIdle: begin
        if (req_i.valid) begin
          q_start_d = req_i.data.seg_start;
          q_end_d   = req_i.data.seg_end;
          q_label_d = req_i.data.seg_label;
          res_d     = '{cost: '0, best_index: '0, status: soc_pkg::StatusOk};
          l_d       = '0;
          r_d       = last_idx;
          case (req_i.data.req_type)
            soc_pkg::ReqClear: begin
              cnt_d = '0;
            end
            soc_pkg::ReqAppend: begin
              if (cnt_q == CntW'(soc_pkg::MaxRefs)) begin
                res_d.status = soc_pkg::StatusFull;
              end else begin
                ram_we = 1'b1;
                cnt_d  = cnt_q + CntW'(1);
              end
              state_d = soc_pkg::StResp;
            end
            soc_pkg::ReqQuery: begin
              if ((req_i.data.seg_label == eps_q) &&
                  (req_i.data.seg_start == req_i.data.seg_end)) begin
                state_d = soc_pkg::StResp;
              end else if (cnt_q == '0) begin
                res_d.status = soc_pkg::StatusEmpty;
                state_d      = soc_pkg::StResp;
              end else if (cnt_q == CntW'(1)) begin
                lo_d    = '0;
                hi_d    = '0;
                state_d = soc_pkg::StWinStart;
              end else begin
                state_d = soc_pkg::StSsStart;
              end
            end
            default: ;
          endcase
        end
      end

      soc_pkg::StSsStart, soc_pkg::StEsStart: begin
        if (init_adj) begin
          if (state_q == soc_pkg::StSsStart) begin
            lo_d    = l_q;
            l_d     = '0;
            r_d     = last_idx;
            state_d = soc_pkg::StEsStart;
          end else begin
            hi_d    = r_q;
            state_d = soc_pkg::StWinStart;
          end
        end else begin
          m_d       = IdxW'(init_sum >> 1);
          ram_raddr = m_d;
          state_d   = (state_q == soc_pkg::StSsStart) ? soc_pkg::StSsEval
                                                      : soc_pkg::StEsEval;
        end
      end

      soc_pkg::StSsEval, soc_pkg::StEsEval: begin
        l_d = nl;
        r_d = nr;
        if (srch_done) begin
          if (state_q == soc_pkg::StSsEval) begin
            lo_d    = nl;
            l_d     = '0;
            r_d     = last_idx;
            state_d = soc_pkg::StEsStart;
          end else begin
            hi_d    = nr;
            state_d = soc_pkg::StWinStart;
          end
        end else begin
          m_d       = nm;
          ram_raddr = nm;
        end
      end

      soc_pkg::StWinStart: begin
        if (lo_q > hi_q) begin
          res_d.status = soc_pkg::StatusEmpty;
          state_d      = soc_pkg::StResp;
        end else begin
          idx_d     = lo_q;
          ram_raddr = lo_q;
          state_d   = soc_pkg::StScan;
        end
      end

      soc_pkg::StScan: begin
        if (take) begin
          best_d     = rd;
          best_ov_d  = ov;
          best_idx_d = idx_q;
        end
        if (idx_q == hi_q) begin
          state_d = soc_pkg::StCost;
        end else begin
          idx_d     = idx_q + IdxW'(1);
          ram_raddr = idx_d;
        end
      end

      soc_pkg::StCost: begin
        res_d   = '{cost: cost_sat, best_index: soc_pkg::BestW'(best_idx_q),
                    status: soc_pkg::StatusOk};
        state_d = soc_pkg::StResp;
      end

      soc_pkg::StResp: begin
        // output register free or being emptied this cycle
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_d     = res_q;
          rsp_vld_d = 1'b1;
          state_d   = soc_pkg::StIdle;
        end
      end

      default: begin
        state_d = soc_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= soc_pkg::StIdle;
      cnt_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q        <= l_d;
    r_q        <= r_d;
    m_q        <= m_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    idx_q      <= idx_d;
    q_start_q  <= q_start_d;
    q_end_q    <= q_end_d;
    q_label_q  <= q_label_d;
    best_q     <= best_d;
    best_ov_q  <= best_ov_d;
    best_idx_q <= best_idx_d;
    res_q      <= res_d;
    rsp_q      <= rsp_d;
  end

endmodule
`default_nettype wire
